// ===== rtl/core/dss_pkg.sv =====
// Shared types and constants of the damped spring stepper.
// Used by the divide-by-125 unit and by the top level; depends on nothing.
package dss_pkg;

  // Width of the dividend that the divider takes apart.
  localparam int unsigned DIV_W     = 46;
  // The dividend is handled in 16-bit digits, most significant first, one digit per cycle.
  localparam int unsigned DIG_W     = 16;
  localparam int unsigned N_DIG     = 3;
  localparam int unsigned DIG_CNT_W = $clog2(N_DIG);
  // The remainder stays below the divisor, so seven bits hold it.
  localparam int unsigned REM_W     = 7;
  localparam logic [REM_W:0] DIVISOR = 8'd125;
  // Rounded-up reciprocal of 125 scaled by 2^30. It gives the exact quotient digit for every
  // partial dividend below 125 * 2^16.
  localparam int unsigned RECIP_W   = 24;
  localparam int unsigned RECIP_SH  = 30;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/dss_div125.sv =====
// Divider by the constant 125, one 16-bit quotient digit per cycle by reciprocal multiplication.
// Depends on dss_pkg for its widths, constants and request/response structs.
module dss_div125
  import dss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned WORK_W = DIG_W * N_DIG;
  localparam int unsigned PART_W = REM_W + DIG_W;
  localparam int unsigned PROD_W = PART_W + RECIP_W;
  localparam logic [DIG_CNT_W-1:0] LAST = DIG_CNT_W'(N_DIG - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIG_CNT_W-1:0] cnt_q;
  logic [WORK_W-1:0]    work_q;
  logic [REM_W-1:0]     rem_q;

  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [DIG_W-1:0]  qdig;
  logic [PART_W-1:0] back;
  logic [PART_W-1:0] rem_nxt;

  // The next digit joins the running remainder; the reciprocal gives its quotient digit.
  assign part    = {rem_q, work_q[WORK_W-1 -: DIG_W]};
  assign prod    = PROD_W'(part) * PROD_W'(RECIP);
  assign qdig    = prod[RECIP_SH +: DIG_W];
  assign back    = PART_W'(qdig) * PART_W'(DIVISOR);
  assign rem_nxt = part - back;

  // The dividend shifts out at the top while quotient digits enter at the bottom.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        work_q <= WORK_W'(req_i.dividend);
        rem_q  <= '0;
      end else if (busy_q) begin
        work_q <= {work_q[WORK_W-DIG_W-1:0], qdig};
        rem_q  <= rem_nxt[REM_W-1:0];
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q[DIV_W-1:0];

endmodule

// ===== rtl/core/damped_spring_step_core.sv =====
// Top level of the damped spring stepper: sequencer, shared multiplier, state and APB registers.
// Depends on dss_pkg and instantiates dss_div125.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_ready_o     | mode_i, dt_ms_i, target_i,
//          |           |                             | start_position_i, start_velocity_i
//  out     | output    | out_valid_o / out_ready_i   | position_o, resting_o
//  apb     | input     | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// A start item, or a step item while the spring is resting, gives its result in the cycle
// after it is accepted. A moving step item runs through multiply, accumulate and round, then
// for the velocity and again for the position it forms the product, starts the divide-by-125
// unit and waits while its three digit steps run and the saturating sum is taken, and last
// it makes the rest test.
// Only one item is in flight; a new item is accepted when the sequencer is idle and the output
// register is empty or being emptied in the same cycle.
// Reset leaves position and velocity at zero, the spring resting, stiffness 200.0, damping 20.0.
module damped_spring_step_core
  import dss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [15:0]        dt_ms_i,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] start_position_i,
  input  logic signed [31:0] start_velocity_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_o,
  output logic               resting_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Register map: stiffness at byte address 0, damping at byte address 4.
  typedef enum logic {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } reg_e;

  typedef enum logic {
    MODE_STEP  = 1'b0,
    MODE_START = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KX,
    ST_CV,
    ST_ACC,
    ST_RND,
    ST_MDV,
    ST_DV_GO,
    ST_DV_WAIT,
    ST_MDX,
    ST_DX_GO,
    ST_DX_WAIT,
    ST_OUT
  } state_e;

  localparam logic [15:0]        STIFF_RESET   = 16'd51200;
  localparam logic [15:0]        DAMP_RESET    = 16'd5120;
  // A zero time step stands for 16 ms, which is 4096 in Q8.8.
  localparam logic [15:0]        DT_DEFAULT    = 16'd4096;
  // Half of 256000, the Q8.8 milliseconds in one second, for round-half-away.
  localparam logic [58:0]        SCALE_HALF    = 59'd128000;
  localparam logic [50:0]        ACC_HALF      = 51'd128;
  localparam logic signed [32:0] REST_POS_LIM  = 33'sd32768;
  localparam logic signed [31:0] REST_VEL_LIM  = 32'sd327680;
  localparam logic [31:0]        SAT_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0]        SAT_MIN       = 32'h8000_0000;

  // Architectural state and configuration.
  state_e             state_q;
  logic [15:0]        k_q;
  logic [15:0]        c_q;
  logic signed [31:0] pos_q;
  logic signed [31:0] vel_q;
  logic               rest_q;

  // Working registers of one step.
  logic [15:0]        dt_q;
  logic signed [31:0] target_q;
  logic [57:0]        prod_q;
  logic               psign_q;
  logic               qsign_q;
  logic signed [49:0] acc_q;
  logic [41:0]        amag_q;
  logic               asign_q;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_pos_q;
  logic               out_rest_q;

  // Combinational datapath.
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [31:0]        vel_mag;
  logic [15:0]        mul_a;
  logic [41:0]        mul_b;
  logic               mul_neg;
  logic [57:0]        mul_p;
  logic signed [49:0] term;
  logic signed [49:0] contrib;
  logic [49:0]        acc_mag;
  logic [50:0]        rnd_sum;
  logic [58:0]        scale_sum;
  logic [39:0]        quot_s;
  logic signed [31:0] add_base;
  logic signed [40:0] add_sum;
  logic signed [31:0] sat_out;
  logic               near_rest;
  logic               out_free;
  logic               cfg_wr;
  reg_e               cfg_idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [31:0] sat32(input logic signed [40:0] v);
    logic [31:0] r;
    if (v[40:31] == {10{v[40]}}) begin
      r = v[31:0];
    end else begin
      r = v[40] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

  // Position error at full width, used for the spring force and for the rest test.
  assign diff     = {pos_q[31], pos_q} - {target_q[31], target_q};
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;
  assign vel_mag  = vel_q[31] ? (~vel_q + 32'd1) : vel_q;

  // The one multiplier works on magnitudes; the sign travels beside the product.
  always_comb begin
    unique case (state_q)
      ST_KX: begin
        mul_a   = k_q;
        mul_b   = 42'(diff_mag);
        mul_neg = diff[32];
      end
      ST_CV: begin
        mul_a   = c_q;
        mul_b   = 42'(vel_mag);
        mul_neg = vel_q[31];
      end
      ST_MDX: begin
        mul_a   = dt_q;
        mul_b   = 42'(vel_mag);
        mul_neg = vel_q[31];
      end
      default: begin
        mul_a   = dt_q;
        mul_b   = amag_q;
        mul_neg = asign_q;
      end
    endcase
  end

  assign mul_p = 58'(mul_a) * 58'(mul_b);

  // The force is the negated product, so a negative operand adds its magnitude.
  assign term    = {1'b0, prod_q[48:0]};
  assign contrib = psign_q ? term : -term;

  // Acceleration in Q16.16: the 24-fraction-bit force rounded half away from zero.
  assign acc_mag = acc_q[49] ? (~acc_q + 50'd1) : acc_q;
  assign rnd_sum = {1'b0, acc_mag} + ACC_HALF;

  // Dividing by 256000 is a rounding shift by eleven bits and then a division by 125.
  assign scale_sum = {1'b0, prod_q} + SCALE_HALF;

  assign div_req.start    = (state_q == ST_DV_GO) || (state_q == ST_DX_GO);
  assign div_req.dividend = scale_sum[56:11];

  dss_div125 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The quotient never reaches 2^39 for velocity changes and stays below 2^30 for position
  // changes, so the low 39 bits carry it.
  assign quot_s = qsign_q ? (~{1'b0, div_rsp.quot[38:0]} + 40'd1) : {1'b0, div_rsp.quot[38:0]};

  // One saturating adder serves the velocity update and then the position update.
  assign add_base = (state_q == ST_DV_WAIT) ? vel_q : pos_q;
  assign add_sum  = {{9{add_base[31]}}, add_base} + {quot_s[39], quot_s};
  assign sat_out  = sat32(add_sum);

  assign near_rest = (diff > -REST_POS_LIM) && (diff < REST_POS_LIM) &&
                     (vel_q > -REST_VEL_LIM) && (vel_q < REST_VEL_LIM);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= STIFF_RESET;
      c_q         <= DAMP_RESET;
      pos_q       <= '0;
      vel_q       <= '0;
      rest_q      <= 1'b1;
      dt_q        <= '0;
      target_q    <= '0;
      prod_q      <= '0;
      psign_q     <= 1'b0;
      qsign_q     <= 1'b0;
      acc_q       <= '0;
      amag_q      <= '0;
      asign_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_rest_q  <= 1'b1;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_STIFFNESS: k_q <= pwdata[15:0];
          REG_DAMPING:   c_q <= pwdata[15:0];
          default:       k_q <= k_q;
        endcase
      end

      prod_q  <= mul_p;
      psign_q <= mul_neg;

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            if (mode_i == MODE_START) begin
              pos_q       <= start_position_i;
              vel_q       <= start_velocity_i;
              rest_q      <= 1'b0;
              out_valid_q <= 1'b1;
              out_pos_q   <= start_position_i;
              out_rest_q  <= 1'b0;
            end else if (rest_q) begin
              out_valid_q <= 1'b1;
              out_pos_q   <= pos_q;
              out_rest_q  <= 1'b1;
            end else begin
              dt_q     <= (dt_ms_i == 16'd0) ? DT_DEFAULT : dt_ms_i;
              target_q <= target_i;
              state_q  <= ST_KX;
            end
          end
        end
        ST_KX: begin
          state_q <= ST_CV;
        end
        ST_CV: begin
          acc_q   <= contrib;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q   <= acc_q + contrib;
          state_q <= ST_RND;
        end
        ST_RND: begin
          amag_q  <= rnd_sum[49:8];
          asign_q <= acc_q[49];
          state_q <= ST_MDV;
        end
        ST_MDV: begin
          state_q <= ST_DV_GO;
        end
        ST_DV_GO: begin
          qsign_q <= psign_q;
          state_q <= ST_DV_WAIT;
        end
        ST_DV_WAIT: begin
          if (div_rsp.done) begin
            vel_q   <= sat_out;
            state_q <= ST_MDX;
          end
        end
        ST_MDX: begin
          state_q <= ST_DX_GO;
        end
        ST_DX_GO: begin
          qsign_q <= psign_q;
          state_q <= ST_DX_WAIT;
        end
        ST_DX_WAIT: begin
          if (div_rsp.done) begin
            pos_q   <= sat_out;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (near_rest) begin
              pos_q      <= target_q;
              vel_q      <= '0;
              rest_q     <= 1'b1;
              out_pos_q  <= target_q;
              out_rest_q <= 1'b1;
            end else begin
              out_pos_q  <= pos_q;
              out_rest_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign resting_o   = out_rest_q;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_STIFFNESS: prdata = {16'd0, k_q};
      REG_DAMPING:   prdata = {16'd0, c_q};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // A resting spring always holds zero velocity.
  a_rest_still : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_q |-> (vel_q == '0))
    else $error("resting flag set with non-zero velocity");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == ST_DV_WAIT) || (state_q == ST_DX_WAIT)))
    else $error("divider finished outside a wait state");

  // A start item is answered in the next cycle with its own position and not resting.
  a_start_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_START)) |=>
      (out_valid_o && !resting_o && (position_o == $past(start_position_i))))
    else $error("start item did not give its result in the next cycle");

endmodule
